// ===== rtl/arc_cosine_sine_lut_interp_unit_defines.svh =====
// Assertion macros shared by the arc cosine / arc sine unit.
// No dependencies; included by the top level only.
`ifndef ARC_COSINE_SINE_LUT_INTERP_UNIT_DEFINES_SVH
`define ARC_COSINE_SINE_LUT_INTERP_UNIT_DEFINES_SVH

// Same-cycle implication, checked while the block is out of reset.
`define ACSL_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while the block is out of reset.
`define ACSL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/acsl_pkg.sv =====
// Package for the arc cosine / arc sine unit: item types, segment codes,
// angle constants and the three interpolation tables. No dependencies.
`default_nettype none

package acsl_pkg;

    typedef struct packed {
        logic signed [15:0] ratio_value;
    } t_in_item;

    typedef struct packed {
        logic        [15:0] arc_cosine;
        logic signed [15:0] arc_sine;
    } t_out_item;

    localparam logic [1:0] SEG_COARSE = 2'd0;
    localparam logic [1:0] SEG_MIDDLE = 2'd1;
    localparam logic [1:0] SEG_FINE   = 2'd2;

    // Result of the table stage: upper entry, slope to the next entry and
    // the fraction within the step.
    typedef struct packed {
        logic [15:0] base;
        logic [9:0]  span;
        logic [8:0]  frac;
        logic [1:0]  seg;
        logic        neg;
    } t_lookup;

    localparam logic [15:0] MIDDLE_START   = 16'h7800;
    localparam logic [15:0] FINE_START     = 16'h7FE0;
    localparam logic [15:0] ANGLE_ALL_ONES = 16'hFFFF;
    localparam logic [15:0] SINE_BIAS      = 16'h7FFF;
    localparam logic [15:0] QUARTER_TURN   = 16'h8000;

    localparam int COARSE_DEPTH = 61;
    localparam int MIDDLE_DEPTH = 64;
    localparam int FINE_DEPTH   = 6;

    localparam logic [15:0] COARSE_TAB [COARSE_DEPTH] = '{
        16'h8000, 16'h7EBA, 16'h7D74, 16'h7C2D, 16'h7AE7, 16'h79A0, 16'h7859, 16'h7711,
        16'h75C9, 16'h7480, 16'h7337, 16'h71EC, 16'h70A1, 16'h6F55, 16'h6E07, 16'h6CB8,
        16'h6B68, 16'h6A17, 16'h68C4, 16'h6770, 16'h661A, 16'h64C1, 16'h6367, 16'h620B,
        16'h60AD, 16'h5F4C, 16'h5DE9, 16'h5C83, 16'h5B1A, 16'h59AE, 16'h583E, 16'h56CB,
        16'h5555, 16'h53DB, 16'h525C, 16'h50D9, 16'h4F51, 16'h4DC5, 16'h4C32, 16'h4A9A,
        16'h48FC, 16'h4757, 16'h45AB, 16'h43F7, 16'h423A, 16'h4075, 16'h3EA5, 16'h3CCB,
        16'h3AE5, 16'h38F1, 16'h36EF, 16'h34DC, 16'h32B7, 16'h307D, 16'h2E2B, 16'h2BBD,
        16'h292E, 16'h2678, 16'h2391, 16'h206C, 16'h1CF6
    };

    localparam logic [15:0] MIDDLE_TAB [MIDDLE_DEPTH] = '{
        16'h1CF6, 16'h1CBB, 16'h1C80, 16'h1C45, 16'h1C08, 16'h1BCC, 16'h1B8F, 16'h1B51,
        16'h1B13, 16'h1AD4, 16'h1A95, 16'h1A55, 16'h1A14, 16'h19D3, 16'h1992, 16'h194F,
        16'h190C, 16'h18C9, 16'h1884, 16'h183F, 16'h17F9, 16'h17B3, 16'h176B, 16'h1723,
        16'h16DA, 16'h1690, 16'h1645, 16'h15F9, 16'h15AC, 16'h155E, 16'h150F, 16'h14BE,
        16'h146D, 16'h141A, 16'h13C6, 16'h1370, 16'h1319, 16'h12C1, 16'h1267, 16'h120B,
        16'h11AD, 16'h114E, 16'h10EC, 16'h1088, 16'h1022, 16'h0FB9, 16'h0F4D, 16'h0EDE,
        16'h0E6C, 16'h0DF7, 16'h0D7D, 16'h0D00, 16'h0C7D, 16'h0BF4, 16'h0B66, 16'h0AD0,
        16'h0A31, 16'h0989, 16'h08D3, 16'h080E, 16'h0734, 16'h063D, 16'h0518, 16'h039A
    };

    // The two trailing zeros let the top of the range interpolate toward zero.
    localparam logic [15:0] FINE_TAB [FINE_DEPTH] = '{
        16'h039A, 16'h031E, 16'h028C, 16'h01CD, 16'h0000, 16'h0000
    };

endpackage

`default_nettype wire

// ===== rtl/acsl_stream_if.sv =====
// Valid/ready channel with a typed payload, used for every transfer in
// the arc cosine / arc sine unit. No dependencies.
`default_nettype none

interface acsl_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/acsl_lookup.sv =====
// Table stage: magnitude, segment choice and lookup of two neighboring
// entries, registered. Depends on acsl_pkg and acsl_stream_if.
`default_nettype none

module acsl_lookup (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    acsl_stream_if.sink    i_req,
    acsl_stream_if.source  o_rsp
);
    import acsl_pkg::*;

    logic        r_valid;
    t_lookup     r_data;
    t_lookup     n_data;

    logic [15:0] raw;
    logic [15:0] mag;
    logic [15:0] fine_full;
    logic [5:0]  fine_off;
    logic [5:0]  coarse_idx;
    logic [5:0]  middle_idx;
    logic [2:0]  fine_idx;
    logic [15:0] upper;
    logic [15:0] lower;
    logic [15:0] span_full;

    assign raw        = i_req.data.ratio_value;
    assign mag        = raw[15] ? (~raw + 16'd1) : raw;
    assign fine_full  = mag - FINE_START;
    assign fine_off   = fine_full[5:0];
    assign coarse_idx = mag[14:9];
    assign middle_idx = mag[10:5];
    assign fine_idx   = fine_off[5:3];

    always_comb begin
        n_data.neg = raw[15];
        if (mag >= FINE_START) begin
            n_data.seg  = SEG_FINE;
            upper       = FINE_TAB[fine_idx];
            lower       = FINE_TAB[fine_idx + 3'd1];
            n_data.frac = {6'd0, fine_off[2:0]};
        end else if (mag >= MIDDLE_START) begin
            n_data.seg  = SEG_MIDDLE;
            upper       = MIDDLE_TAB[middle_idx];
            lower       = MIDDLE_TAB[middle_idx + 6'd1];
            n_data.frac = {4'd0, mag[4:0]};
        end else begin
            n_data.seg  = SEG_COARSE;
            upper       = COARSE_TAB[coarse_idx];
            lower       = COARSE_TAB[coarse_idx + 6'd1];
            n_data.frac = mag[8:0];
        end
        // Tables decrease, so the span is never negative and fits ten bits.
        span_full   = upper - lower;
        n_data.base = upper;
        n_data.span = span_full[9:0];
    end

    assign i_req.ready = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_data <= n_data;
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/acsl_interp.sv =====
// Interpolation stage: one multiply, segment shift, subtraction and sign
// mirroring into the result register. Depends on acsl_pkg, acsl_stream_if.
`default_nettype none

module acsl_interp (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    acsl_stream_if.sink    i_req,
    acsl_stream_if.source  o_rsp
);
    import acsl_pkg::*;

    logic        r_valid;
    t_out_item   r_data;
    t_out_item   n_data;

    t_lookup     lk;
    logic [18:0] prod;
    logic [15:0] delta;
    logic [15:0] angle;

    assign lk   = i_req.data;
    assign prod = lk.span * lk.frac;

    always_comb begin
        case (lk.seg)
            SEG_COARSE: delta = {6'd0, prod[18:9]};
            SEG_MIDDLE: delta = {5'd0, prod[15:5]};
            SEG_FINE:   delta = {3'd0, prod[15:3]};
            default:    delta = 16'd0;
        endcase
        angle = lk.base - delta;
        if (lk.neg) begin
            n_data.arc_cosine = ANGLE_ALL_ONES - angle;
            n_data.arc_sine   = angle - QUARTER_TURN;
        end else begin
            n_data.arc_cosine = angle;
            n_data.arc_sine   = SINE_BIAS - angle;
        end
    end

    assign i_req.ready = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_data <= n_data;
        end
    end

    assign o_rsp.valid = r_valid;
    assign o_rsp.data  = r_data;

endmodule

`default_nettype wire

// ===== rtl/arc_cosine_sine_lut_interp_unit.sv =====
// Channel     Dir  Payload
// i_in_chan   in   ratio_value (signed Q15)
// o_out_chan  out  arc_cosine, arc_sine (0x10000 per half turn)
//
// Three register stages: input register, table lookup, interpolation.
// A result passes the input register, table lookup and interpolation in
// that order; one item per cycle while the output is not stalled.
// The multiply in the interpolation stage is the longest path.
// Reset is synchronous, active low, and clears only the stage valid bits.
// A stalled output holds each stage; empty stages still take new items.
`default_nettype none
`include "arc_cosine_sine_lut_interp_unit_defines.svh"

module arc_cosine_sine_lut_interp_unit (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    acsl_stream_if.sink    i_in_chan,
    acsl_stream_if.source  o_out_chan
);
    import acsl_pkg::*;

    logic               r_s0_valid;
    logic signed [15:0] r_s0_value;

    acsl_stream_if #(.T(t_in_item)) s0_chan ();
    acsl_stream_if #(.T(t_lookup))  s1_chan ();

    assign i_in_chan.ready = !r_s0_valid || s0_chan.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (i_in_chan.ready) begin
            r_s0_valid <= i_in_chan.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_chan.valid && i_in_chan.ready) begin
            r_s0_value <= i_in_chan.data.ratio_value;
        end
    end

    assign s0_chan.valid            = r_s0_valid;
    assign s0_chan.data.ratio_value = r_s0_value;

    acsl_lookup u_lookup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s0_chan),
        .o_rsp   (s1_chan)
    );

    acsl_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s1_chan),
        .o_rsp   (o_out_chan)
    );

    // Both outputs come from one base angle, and their sum is fixed either way.
    `ACSL_ASSERT_SAME(a_angle_sum, i_clk, i_rst_n, o_out_chan.valid,
        (o_out_chan.data.arc_cosine + o_out_chan.data.arc_sine) == SINE_BIAS,
        "arc_cosine plus arc_sine differs from the fixed sum")
    `ACSL_ASSERT_NEXT(a_in_loads_s0, i_clk, i_rst_n,
        i_in_chan.valid && i_in_chan.ready, r_s0_valid,
        "accepted transfer did not reach the input register")
    `ACSL_ASSERT_NEXT(a_s0_holds, i_clk, i_rst_n,
        r_s0_valid && !s0_chan.ready, r_s0_valid && $stable(r_s0_value),
        "input register changed while its transfer was stalled")

endmodule

`default_nettype wire
